// ===== sv/swm_pkg.sv =====
package swm_pkg;

  // sample and register widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;

  // built maximum of the moving window
  localparam int MAX_WINDOW_DEF = 64;

  // window size after reset
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  // configuration port: one 32-bit register at byte address 0
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  // controls broadcast to every cell of the sorted row
  typedef struct packed {
    logic update;  // take the next sorted slot value
    logic remove;  // window full: oldest sample leaves the row
    logic clear;   // empty the row
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PICK
  } swm_state_e;

endpackage

// ===== sv/swm_in_if.sv =====
interface swm_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [swm_pkg::DATA_W-1:0] sample;
  logic                              last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== sv/swm_out_if.sv =====
interface swm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [swm_pkg::DATA_W-1:0] median;
  logic                              sequence_end;

  modport source (output valid, output median, output sequence_end, input ready);
  modport sink   (input valid, input median, input sequence_end, output ready);
endinterface

// ===== sv/swm_cell.sv =====
module swm_cell #(
  parameter int AGE_W = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swm_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [swm_pkg::DATA_W-1:0] key_i,
  input  logic signed [swm_pkg::DATA_W-1:0] old_i,
  // slot of the lower neighbor after removal
  input  logic                              dn_vld_i,
  input  logic signed [swm_pkg::DATA_W-1:0] dn_val_i,
  input  logic [AGE_W-1:0]                  dn_age_i,
  input  logic                              dn_le_i,
  // stored value of the upper neighbor
  input  logic                              up_vld_i,
  input  logic signed [swm_pkg::DATA_W-1:0] up_val_i,
  input  logic [AGE_W-1:0]                  up_age_i,
  input  logic                              up_le_i,
  // own stored value
  output logic                              vld_o,
  output logic signed [swm_pkg::DATA_W-1:0] val_o,
  output logic [AGE_W-1:0]                  age_o,
  output logic                              le_o,
  // own slot after removal
  output logic                              lp_vld_o,
  output logic signed [swm_pkg::DATA_W-1:0] lp_val_o,
  output logic [AGE_W-1:0]                  lp_age_o,
  output logic                              lp_le_o
);

  logic                              vld_q, vld_d;
  logic signed [swm_pkg::DATA_W-1:0] val_q, val_d;
  logic [AGE_W-1:0]                  age_q, age_d;
  logic                              lt_old;
  logic                              shift_dn;

  // the oldest entry is the lowest of its equals, so everything not below it moves down
  assign lt_old   = vld_q && (val_q < old_i);
  assign le_o     = vld_q && (val_q <= key_i);
  assign shift_dn = ctrl_i.remove && !lt_old;

  assign lp_vld_o = shift_dn ? up_vld_i : vld_q;
  assign lp_val_o = shift_dn ? up_val_i : val_q;
  assign lp_age_o = shift_dn ? up_age_i : age_q;
  assign lp_le_o  = shift_dn ? up_le_i  : le_o;

  // insert: keep own slot at or below the key, take the key at its place, else take from below
  always_comb begin
    if (lp_le_o) begin
      vld_d = lp_vld_o;
      val_d = lp_val_o;
      age_d = lp_age_o + AGE_W'(1);
    end else if (dn_le_i) begin
      vld_d = 1'b1;
      val_d = key_i;
      age_d = '0;
    end else begin
      vld_d = dn_vld_i;
      val_d = dn_val_i;
      age_d = dn_age_i + AGE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.update) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign vld_o = vld_q;
  assign val_o = val_q;
  assign age_o = age_q;

endmodule

// ===== sv/sliding_window_median.sv =====
// Lower-median filter over a moving window of signed 32-bit samples. The window
// lives in a row of MAX_WINDOW cells kept in ascending order; each cell holds one
// sample and its age and exchanges values with its two neighbors when an item
// comes in, so the oldest sample leaves and the new one drops into place in a
// single step. An item passes through capture (and lookup of the oldest
// sample), the shift of the cell row, and the pick of the median into the output
// register; the pick waits while a previous result is still not taken. A result
// appears once the active window (window_size clamped to 1 .. MAX_WINDOW) is
// full; last_sample marks the result and empties the window. Writing window_size
// (register 0) also empties the window. No clearing pass follows reset.
module sliding_window_median #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  swm_in_if.sink                      in_i,
  swm_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swm_pkg::APB_AW-1:0]  paddr,
  input  logic [swm_pkg::APB_DW-1:0]  pwdata,
  output logic [swm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int DW   = swm_pkg::DATA_W;
  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNTW = ($clog2(MAX_WINDOW + 1) > swm_pkg::CFG_W) ?
                        $clog2(MAX_WINDOW + 1) : swm_pkg::CFG_W;

  swm_pkg::swm_state_e state_q, state_d;
  swm_pkg::cell_ctrl_t ctrl;

  logic [swm_pkg::CFG_W-1:0] window_size_q;
  logic [CNTW-1:0]           ws_ext;
  logic [CNTW-1:0]           w_eff;
  logic [CNTW-1:0]           n_q, n_d;
  logic [AW-1:0]             mid;
  logic                      cfg_we;
  logic                      in_take;
  logic                      full;
  logic                      has_res;
  logic                      out_free;
  logic                      load;

  logic signed [DW-1:0] key_q;
  logic signed [DW-1:0] old_q;
  logic signed [DW-1:0] old_sel;
  logic                 last_q;

  logic                 out_vld_q;
  logic signed [DW-1:0] median_q;
  logic                 seq_end_q;

  logic                 c_vld    [MAX_WINDOW];
  logic signed [DW-1:0] c_val    [MAX_WINDOW];
  logic [AW-1:0]        c_age    [MAX_WINDOW];
  logic                 c_le     [MAX_WINDOW];
  logic                 c_lp_vld [MAX_WINDOW];
  logic signed [DW-1:0] c_lp_val [MAX_WINDOW];
  logic [AW-1:0]        c_lp_age [MAX_WINDOW];
  logic                 c_lp_le  [MAX_WINDOW];

  // configuration register
  assign cfg_we = psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == swm_pkg::REG_WINDOW) ?
                  swm_pkg::APB_DW'(window_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= swm_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_size_q <= pwdata[swm_pkg::CFG_W-1:0];
    end
  end

  // active window, clamped to 1 .. MAX_WINDOW
  assign ws_ext = CNTW'(window_size_q);
  always_comb begin
    if (ws_ext == '0) begin
      w_eff = CNTW'(1);
    end else if (ws_ext > CNTW'(MAX_WINDOW)) begin
      w_eff = CNTW'(MAX_WINDOW);
    end else begin
      w_eff = ws_ext;
    end
  end

  assign mid      = AW'((w_eff - CNTW'(1)) >> 1);
  assign full     = (n_q == w_eff);
  assign has_res  = (n_q == w_eff);
  assign out_free = !out_vld_q || out_o.ready;
  assign in_take  = in_i.valid && in_i.ready;

  // oldest sample of a full window: the cell whose age is window - 1
  always_comb begin
    old_sel = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (c_vld[i] && (CNTW'(c_age[i]) == w_eff - CNTW'(1))) begin
        old_sel = old_sel | c_val[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      key_q  <= in_i.sample;
      last_q <= in_i.last_sample;
      old_q  <= old_sel;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swm_pkg::ST_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    ctrl        = '0;
    load        = 1'b0;
    in_i.ready  = 1'b0;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = swm_pkg::ST_SHIFT;
        end
      end
      swm_pkg::ST_SHIFT: begin
        ctrl.update = 1'b1;
        ctrl.remove = full;
        n_d         = full ? n_q : n_q + CNTW'(1);
        state_d     = swm_pkg::ST_PICK;
      end
      swm_pkg::ST_PICK: begin
        if (!has_res || out_free) begin
          load    = has_res;
          state_d = swm_pkg::ST_IDLE;
          if (last_q) begin
            ctrl.clear = 1'b1;
            n_d        = '0;
          end
        end
      end
      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
    // a window size write restarts the sequence
    if (cfg_we) begin
      ctrl.clear = 1'b1;
      n_d        = '0;
    end
  end

  // sorted cell row
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                 dn_vld;
    logic signed [DW-1:0] dn_val;
    logic [AW-1:0]        dn_age;
    logic                 dn_le;
    logic                 up_vld;
    logic signed [DW-1:0] up_val;
    logic [AW-1:0]        up_age;
    logic                 up_le;

    if (i == 0) begin : g_bottom
      assign dn_vld = 1'b0;
      assign dn_val = '0;
      assign dn_age = '0;
      assign dn_le  = 1'b1;
    end else begin : g_mid_dn
      assign dn_vld = c_lp_vld[i-1];
      assign dn_val = c_lp_val[i-1];
      assign dn_age = c_lp_age[i-1];
      assign dn_le  = c_lp_le[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_top
      assign up_vld = 1'b0;
      assign up_val = '0;
      assign up_age = '0;
      assign up_le  = 1'b0;
    end else begin : g_mid_up
      assign up_vld = c_vld[i+1];
      assign up_val = c_val[i+1];
      assign up_age = c_age[i+1];
      assign up_le  = c_le[i+1];
    end

    swm_cell #(
      .AGE_W (AW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .key_i    (key_q),
      .old_i    (old_q),
      .dn_vld_i (dn_vld),
      .dn_val_i (dn_val),
      .dn_age_i (dn_age),
      .dn_le_i  (dn_le),
      .up_vld_i (up_vld),
      .up_val_i (up_val),
      .up_age_i (up_age),
      .up_le_i  (up_le),
      .vld_o    (c_vld[i]),
      .val_o    (c_val[i]),
      .age_o    (c_age[i]),
      .le_o     (c_le[i]),
      .lp_vld_o (c_lp_vld[i]),
      .lp_val_o (c_lp_val[i]),
      .lp_age_o (c_lp_age[i]),
      .lp_le_o  (c_lp_le[i])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      median_q  <= c_val[mid];
      seq_end_q <= last_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.median       = median_q;
  assign out_o.sequence_end = seq_end_q;

endmodule

// ===== sv/swm_checker.sv =====
module swm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [swm_pkg::DATA_W-1:0] out_median_i,
  input logic                              out_seq_end_i
);

  // one item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted in the cycle after an accept");

  // a new result is loaded only while the input side is busy with an item
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without an item in flight");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_median_i) && $stable(out_seq_end_i)))
    else $error("stalled result changed");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_median_i  (out_o.median),
  .out_seq_end_i (out_o.sequence_end)
);
